@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: cond holds at an edge, so does expr.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication: cond holds at an edge, expr holds at the next one.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

@@ hdl/plsu_pkg.sv @@
// ---------------------------------------------------------------------------
// plsu_pkg
// Shared constants and types of the positional list store.
// ---------------------------------------------------------------------------
`default_nettype none

package plsu_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int CNT_OUT_W    = 7;

  // op codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;  // insert: load at target, shift up above it
    logic             del;  // delete: shift down from target on
    logic [POS_W-1:0] tgt;  // 0-based target cell
  } ctrl_t;

endpackage

`default_nettype wire

@@ hdl/positional_list_store_unit.sv @@
// ---------------------------------------------------------------------------
// positional_list_store_unit
// Fixed-capacity list with insert, delete and read at a 1-based position.
// ---------------------------------------------------------------------------
//
//   channel | handshake        | payload                                   | dir
//   --------+------------------+-------------------------------------------+----
//   request | valid_i, stall_o | op_i, position_i, value_i                 | in
//   result  | valid_o, stall_i | status_o, element_o, count_o, empty_res_o | out
//
// All cells shift or hold in parallel in the cycle the request is taken, and
// the result lands in the output register. The chain of cells does one step
// per request, no iteration. A new request is taken while the result register
// is free or being drained. Reset clears the entry count and the result
// valid; entry contents stay undefined until written and are never read
// before that.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module positional_list_store_unit #(
  parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                stall_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic [plsu_pkg::POS_W-1:0]     position_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]    value_i,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic      [1:0]                     status_o,
  output logic      [plsu_pkg::DATA_W-1:0]    element_o,
  output logic      [plsu_pkg::CNT_OUT_W-1:0] count_o,
  output logic                                empty_res_o
);

  // count width holds CAPACITY itself; compare width covers count+1 and position
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = ((CntW > plsu_pkg::POS_W) ? CntW : plsu_pkg::POS_W) + 1;

  logic [CntW-1:0]             count_q, count_d;
  logic                        out_valid_q;
  logic [1:0]                  status_q, status_d;
  logic [plsu_pkg::DATA_W-1:0] element_q, element_d;
  logic [plsu_pkg::CNT_OUT_W-1:0] count_out_q;
  logic                        empty_q;

  logic                        accept;
  logic [CmpW-1:0]             pos_x, cnt_x;
  logic                        pos_zero, ins_bad, rd_bad, full;
  logic                        do_ins, do_del;
  plsu_pkg::ctrl_t             ctrl;
  logic [plsu_pkg::DATA_W-1:0] rd_data;
  logic                        res_fail;

  // take a transfer when the result register is free or drains this cycle
  assign stall_o = out_valid_q && stall_i;
  assign accept  = valid_i && !stall_o;

  assign pos_x    = CmpW'(position_i);
  assign cnt_x    = CmpW'(count_q);
  assign pos_zero = (position_i == '0);
  assign ins_bad  = pos_zero || (pos_x > (cnt_x + CmpW'(1)));
  assign rd_bad   = pos_zero || (pos_x > cnt_x);
  assign full     = (count_q == CntW'(CAPACITY));

  // decode: status, element and the shift command for the cells
  always_comb begin
    status_d  = plsu_pkg::ST_OK;
    element_d = '0;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    unique case (op_i)
      plsu_pkg::OP_INSERT: begin
        if (ins_bad) begin
          status_d = plsu_pkg::ST_RANGE;
        end else if (full) begin
          status_d = plsu_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      plsu_pkg::OP_DELETE: begin
        if (rd_bad) begin
          status_d = plsu_pkg::ST_RANGE;
        end else begin
          element_d = rd_data;
          do_del    = 1'b1;
        end
      end
      plsu_pkg::OP_READ: begin
        if (rd_bad) begin
          status_d = plsu_pkg::ST_RANGE;
        end else begin
          element_d = rd_data;
        end
      end
      default: begin
        // unused op code: reject, list unchanged
        status_d = plsu_pkg::ST_RANGE;
      end
    endcase
  end

  // cell command only fires on an accepted transfer
  assign ctrl.ins = accept && do_ins;
  assign ctrl.del = accept && do_del;
  assign ctrl.tgt = position_i - plsu_pkg::POS_W'(1);

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_del) begin
      count_d = count_q - CntW'(1);
    end
  end

  plsu_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .value_i   (value_i),
    .rd_data_o (rd_data)
  );

  // control state: entry count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      element_q   <= element_d;
      count_out_q <= plsu_pkg::CNT_OUT_W'(count_d);
      empty_q     <= (count_d == '0);
    end
  end

  assign valid_o     = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign count_o     = count_out_q;
  assign empty_res_o = empty_q;

  // a waiting result that reports a failure
  assign res_fail = out_valid_q && (status_q != plsu_pkg::ST_OK);

  // entry count never passes the capacity
  `ASSERT_IMPLIES(a_cnt_cap, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY))
  // a successful insert grows the count by exactly one
  `ASSERT_NEXT(a_ins_grow, clk_i, rst_ni, ctrl.ins, count_q == CntW'($past(count_q) + 1'b1))
  // a waiting result agrees with the live count on emptiness
  `ASSERT_IMPLIES(a_empty, clk_i, rst_ni, out_valid_q, empty_q == (count_q == '0))
  // failed operations return a zero element
  `ASSERT_IMPLIES(a_fail_zero, clk_i, rst_ni, res_fail, element_q == '0)

endmodule

`default_nettype wire

@@ hdl/plsu_cell.sv @@
// ---------------------------------------------------------------------------
// plsu_cell
// One list entry: holds, loads, or takes its left or right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module plsu_cell #(
  parameter int IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire plsu_pkg::ctrl_t               ctrl_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]   value_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]   left_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]   right_i,
  output logic      [plsu_pkg::DATA_W-1:0]   data_o,
  output logic      [plsu_pkg::DATA_W-1:0]   sel_o
);

  localparam logic [31:0] IdxL = 32'(IDX);

  logic [plsu_pkg::DATA_W-1:0] data_q, data_d;
  logic                        is_tgt;
  logic                        above;

  assign is_tgt = (IdxL == 32'(ctrl_i.tgt));
  assign above  = (IdxL > 32'(ctrl_i.tgt));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (is_tgt) begin
        data_d = value_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (is_tgt || above) begin
        data_d = right_i;
      end
    end
  end

  // entry contents are undefined until written: no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign sel_o  = is_tgt ? data_q : '0;

endmodule

`default_nettype wire

@@ hdl/plsu_chain.sv @@
// ---------------------------------------------------------------------------
// plsu_chain
// Row of entry cells with neighbor links and the selected-entry read.
// ---------------------------------------------------------------------------
`default_nettype none

module plsu_chain #(
  parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk_i,
  input  wire plsu_pkg::ctrl_t               ctrl_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]   value_i,
  output logic      [plsu_pkg::DATA_W-1:0]   rd_data_o
);

  logic [plsu_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [plsu_pkg::DATA_W-1:0] cell_sel  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [plsu_pkg::DATA_W-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    plsu_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .sel_o   (cell_sel[g])
    );
  end

  // at most one cell is selected: merge by OR
  always_comb begin
    rd_data_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data_o = rd_data_o | cell_sel[i];
    end
  end

endmodule

`default_nettype wire

@@ verif/list_store_checker.sv @@
// ---------------------------------------------------------------------------
// list_store_checker
// Watches both channels of the positional list store, keeps its own copy of
// the list, and compares every result transfer with the predicted one.
// ---------------------------------------------------------------------------
`default_nettype none

module list_store_checker #(
  parameter int CAPACITY = plsu_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  input  wire logic                           req_stall_i,
  input  wire logic [1:0]                     op_i,
  input  wire logic [plsu_pkg::POS_W-1:0]     position_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]    value_i,
  input  wire logic                           res_valid_i,
  input  wire logic                           res_stall_i,
  input  wire logic [1:0]                     status_i,
  input  wire logic [plsu_pkg::DATA_W-1:0]    element_i,
  input  wire logic [plsu_pkg::CNT_OUT_W-1:0] count_i,
  input  wire logic                           empty_res_i,
  output int                                  err_count_o,
  output int                                  pending_o,
  output int                                  fill_o
);

  import plsu_pkg::*;

  typedef struct packed {
    logic [1:0]           status;
    logic [DATA_W-1:0]    element;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty;
  } list_result_t;

  logic [DATA_W-1:0] entries_q[$];
  list_result_t      result_q[$];
  list_result_t      want;
  int                err_cnt = 0;

  assign err_count_o = err_cnt;

  // Apply one request to the shadow list and return the result it yields.
  function automatic list_result_t apply_request(logic [1:0] op, logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] val);
    list_result_t r;
    int           len;
    int           p;
    len = entries_q.size();
    p   = int'(pos);
    r   = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > len + 1) begin
          r.status = ST_RANGE;
        end else if (len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          entries_q.insert(p - 1, val);
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > len) begin
          r.status = ST_RANGE;
        end else begin
          r.element = entries_q[p - 1];
          entries_q.delete(p - 1);
        end
      end
      OP_READ: begin
        if (p < 1 || p > len) begin
          r.status = ST_RANGE;
        end else begin
          r.element = entries_q[p - 1];
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.count = CNT_OUT_W'(entries_q.size());
    r.empty = (entries_q.size() == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q.delete();
      result_q.delete();
      pending_o <= 0;
      fill_o    <= 0;
    end else begin
      if (req_valid_i && !req_stall_i) begin
        result_q.push_back(apply_request(op_i, position_i, value_i));
      end
      if (res_valid_i && !res_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected: status %0d element %h count %0d",
                   $time, status_i, element_i, count_i);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status_i);
            err_cnt++;
          end
          if (element_i !== want.element) begin
            $display("%0t: element mismatch: expected %h, got %h",
                     $time, want.element, element_i);
            err_cnt++;
          end
          if (count_i !== want.count) begin
            $display("%0t: count mismatch: expected %0d, got %0d",
                     $time, want.count, count_i);
            err_cnt++;
          end
          if (empty_res_i !== want.empty) begin
            $display("%0t: empty flag mismatch: expected %0d, got %0d",
                     $time, want.empty, empty_res_i);
            err_cnt++;
          end
        end
      end
      pending_o <= result_q.size();
      fill_o    <= entries_q.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives the positional list store with a short directed sequence and then
// random bursts of insert, delete and read requests, under random stalls on
// the result side. A checker beside the block predicts and compares every
// result; this module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  import plsu_pkg::*;

  // Op code with no function: the block must reject it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Receiver stall patterns.
  localparam int RX_FREE   = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;
  localparam int RX_TOGGLE = 3;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int GROW_SPAN      = 150;   // items per insert-heavy or delete-heavy run
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int TAIL_CYCLES    = 4;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 valid_i    = 1'b0;
  logic [1:0]           op_i       = OP_INSERT;
  logic [POS_W-1:0]     position_i = '0;
  logic [DATA_W-1:0]    value_i    = '0;
  logic                 stall_i    = 1'b0;
  logic                 stall_o;
  logic                 valid_o;
  logic [1:0]           status_o;
  logic [DATA_W-1:0]    element_o;
  logic [CNT_OUT_W-1:0] count_o;
  logic                 empty_res_o;

  int err_w;
  int pending_w;
  int fill_w;
  int hold_req = 0;   // bump to ask the receiver for one long hold-off

  positional_list_store_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .op_i        (op_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o)
  );

  list_store_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (valid_i),
    .req_stall_i (stall_o),
    .op_i        (op_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_valid_i (valid_o),
    .res_stall_i (stall_i),
    .status_i    (status_o),
    .element_i   (element_o),
    .count_i     (count_o),
    .empty_res_i (empty_res_o),
    .err_count_o (err_w),
    .pending_o   (pending_w),
    .fill_o      (fill_w)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request and hold it until the transfer happens. Valid stays
  // high on return, so a following request goes out back to back.
  task automatic send_req(input logic [1:0] op, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] val);
    valid_i    <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  // Drop valid for a gap of the given length.
  task automatic idle_for(input int cycles);
    valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop valid and wait until every outstanding result has been taken. The
  // first edge lets the checker count a request taken at the previous one.
  task automatic drain_results();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_w != 0) @(posedge clk_i);
  endtask

  // Build one random request. The fill level seen here may lag by one
  // transfer; that only shifts the odds of a range error.
  task automatic pick_req(input bit grow, output logic [1:0] op,
                          output logic [POS_W-1:0] pos, output logic [DATA_W-1:0] val);
    int roll;
    int len;
    len  = fill_w;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      op = OP_UNUSED;
    end else if (roll < (grow ? 68 : 23)) begin
      op = OP_INSERT;
    end else if (roll < 83) begin
      op = OP_DELETE;
    end else begin
      op = OP_READ;
    end
    // Mostly legal positions; the rest spans the whole field, zero included.
    if ($urandom_range(0, 99) < 12) begin
      pos = POS_W'($urandom_range(0, 127));
    end else if (op == OP_INSERT) begin
      pos = POS_W'($urandom_range(1, len + 1));
    end else begin
      pos = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, len));
    end
    case ($urandom_range(0, 19))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'h0000_0000;
      3:       val = 32'hFFFF_FFFF;
      default: val = $urandom();
    endcase
  endtask

  // Receiver: random stall patterns in stretches, plus a long hold-off on
  // request while the sender keeps offering, so the block backs up.
  initial begin : rx_stall
    int mode;
    int span;
    int hold_seen;
    hold_seen = 0;
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(RX_FREE, RX_TOGGLE);
        span = $urandom_range(10, 150);
        repeat (span) begin
          @(posedge clk_i);
          case (mode)
            RX_FREE:  stall_i <= 1'b0;
            RX_LIGHT: stall_i <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: stall_i <= ($urandom_range(0, 3) != 0);
            default:  stall_i <= ~stall_i;
          endcase
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [1:0]        op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int                sent;
    int                burst;
    bit                grow;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, bad positions, extreme values, front, middle and
    // back of the list, the unused op code, and back down to empty.
    send_req(OP_READ,   7'd1,   32'h1234_5678);  // read of an empty list
    send_req(OP_DELETE, 7'd1,   32'h0);          // delete from an empty list
    send_req(OP_INSERT, 7'd0,   32'h1111_1111);  // position zero
    send_req(OP_INSERT, 7'd2,   32'h2222_2222);  // past the end
    send_req(OP_INSERT, 7'd127, 32'h0);          // top of the position field
    send_req(OP_INSERT, 7'd1,   32'h8000_0000);
    send_req(OP_INSERT, 7'd2,   32'h7FFF_FFFF);  // append
    send_req(OP_INSERT, 7'd1,   32'hFFFF_FFFF);  // push to the front
    send_req(OP_INSERT, 7'd2,   32'h0000_0000);  // middle
    send_req(OP_READ,   7'd4,   32'h0);          // last entry
    send_req(OP_READ,   7'd5,   32'h0);          // one past the end
    send_req(OP_READ,   7'd0,   32'h0);
    send_req(OP_UNUSED, 7'd1,   32'h5A5A_5A5A);
    send_req(OP_DELETE, 7'd2,   32'h0);          // middle
    send_req(OP_DELETE, 7'd3,   32'h0);          // last
    send_req(OP_DELETE, 7'd1,   32'h0);          // front
    send_req(OP_INSERT, 7'd3,   32'h3333_3333);  // past the end with one entry
    send_req(OP_DELETE, 7'd1,   32'h0);          // back to empty
    send_req(OP_READ,   7'd1,   32'h0);
    drain_results();

    // Random bursts. Alternate insert-heavy and delete-heavy runs so the
    // list sweeps between empty and full many times.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        if (sent == 300 || sent == 1000) hold_req++;
        if (sent == 700) drain_results();
        grow = ((sent / GROW_SPAN) % 2) == 0;
        pick_req(grow, op, pos, val);
        send_req(op, pos, val);
        sent++;
        burst--;
      end
      // Roughly a third of the bursts run straight into the next one.
      if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_w == 0 && pending_w == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
